// ===== hw/rtl/tun_pkg.sv =====
// shared types and constants for the triangle unit normal block
`timescale 1ns / 1ps

package tun_pkg;

  localparam int CoordW   = 32;
  localparam int EdgeW    = 33;
  localparam int ProdW    = 66;
  localparam int CrossW   = 67;
  localparam int CompW    = 31;
  localparam int PosW     = 7;
  localparam int SqW      = 62;
  localparam int SumW     = 64;
  localparam int LenW     = 32;
  localparam int NumW     = 62;
  localparam int QuotW    = 32;
  localparam int FracBits = 30;
  localparam int RootSteps = 32;
  localparam int DivSteps  = 32;

  localparam logic [QuotW-1:0] OneQ30 = 32'h4000_0000;

  // input request: three vertices in Q16.16
  typedef struct packed {
    logic signed [CoordW-1:0] vertex_a_x;
    logic signed [CoordW-1:0] vertex_a_y;
    logic signed [CoordW-1:0] vertex_a_z;
    logic signed [CoordW-1:0] vertex_b_x;
    logic signed [CoordW-1:0] vertex_b_y;
    logic signed [CoordW-1:0] vertex_b_z;
    logic signed [CoordW-1:0] vertex_c_x;
    logic signed [CoordW-1:0] vertex_c_y;
    logic signed [CoordW-1:0] vertex_c_z;
  } in_req_t;

  // output request: unit normal in Q1.30
  typedef struct packed {
    logic signed [CoordW-1:0] normal_x;
    logic signed [CoordW-1:0] normal_y;
    logic signed [CoordW-1:0] normal_z;
    logic                     degenerate;
  } out_req_t;

  // block-normalized cross product handed from front to back
  typedef struct packed {
    logic [2:0][CompW-1:0] comp;
    logic [2:0]            neg;
    logic                  degen;
  } item_t;

endpackage

// ===== hw/rtl/triangle_unit_normal_core.sv =====
// top level of the triangle unit normal block
// The input channel takes one triangle request (vertices A, B, C in signed
// Q16.16) per cycle while in_ready_o is high, on in_valid_i / in_ready_o /
// in_req_i. The output channel returns one request per triangle on
// out_valid_o / out_ready_i / out_req_o: the unit face normal in signed
// Q1.30 and a degenerate flag, set with a zero normal when the cross
// product is exactly zero. Throughput is one triangle per cycle while the
// receiver does not stall. The path runs through 5 front stages (edges,
// products, cross sum, leading-one search, block shift), the queue,
// 2 stages of squares and sum, 32 square-root stages (one root bit each),
// one numerator stage, 32 divider stages (one quotient bit each, three
// lanes) and the output register.
// Reset clears all valid state; nothing is kept between triangles.
// When the receiver stalls, the back pipeline holds, the queue fills, and
// the front pipeline then holds and drops in_ready_o.
`timescale 1ns / 1ps

module triangle_unit_normal_core #(
  parameter int QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tun_pkg::in_req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tun_pkg::out_req_t  out_req_o
);

  logic           f_valid, f_ready, b_valid, b_ready;
  tun_pkg::item_t f_item, b_item;

  // classify and normalize
  tun_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  // decoupling queue
  tun_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_item_o   (b_item)
  );

  // length and division
  tun_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (b_valid),
    .item_ready_o (b_ready),
    .item_i       (b_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_req_o    (out_req_o)
  );

endmodule

// ===== hw/rtl/tun_front.sv =====
// front: edges, exact cross product and block normalization
`timescale 1ns / 1ps

module tun_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tun_pkg::in_req_t in_req_i,
  output logic             item_valid_o,
  input  logic             item_ready_i,
  output tun_pkg::item_t   item_o
);

  logic en;
  logic [4:0] vld_q;

  logic signed [tun_pkg::EdgeW-1:0]  u_q [3];
  logic signed [tun_pkg::EdgeW-1:0]  v_q [3];
  logic signed [tun_pkg::ProdW-1:0]  pa_q [3];
  logic signed [tun_pkg::ProdW-1:0]  pb_q [3];
  logic [tun_pkg::CrossW-1:0]        m3_q [3];
  logic [2:0]                        neg3_q;
  logic [tun_pkg::CrossW-1:0]        m4_q [3];
  logic [2:0]                        neg4_q;
  logic                              deg4_q;
  logic [tun_pkg::PosW-1:0]          pos4_q;
  tun_pkg::item_t                    item_q;

  logic signed [tun_pkg::CrossW-1:0] n_d [3];
  logic [tun_pkg::CrossW-1:0]        or_d;
  logic [tun_pkg::PosW-1:0]          pos_d;
  logic [tun_pkg::CrossW-1:0]        sh_d [3];

  assign en           = !vld_q[4] || item_ready_i;
  assign in_ready_o   = en;
  assign item_valid_o = vld_q[4];
  assign item_o       = item_q;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  // differences, leading one, shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_d[i] = tun_pkg::CrossW'(pa_q[i]) - tun_pkg::CrossW'(pb_q[i]);
    end
    or_d  = m3_q[0] | m3_q[1] | m3_q[2];
    pos_d = '0;
    for (int b = 0; b < tun_pkg::CrossW; b++) begin
      if (or_d[b]) pos_d = tun_pkg::PosW'(b);
    end
    for (int i = 0; i < 3; i++) begin
      if (pos4_q > tun_pkg::PosW'(tun_pkg::FracBits)) begin
        sh_d[i] = m4_q[i] >> (pos4_q - tun_pkg::PosW'(tun_pkg::FracBits));
      end else begin
        sh_d[i] = m4_q[i] << (tun_pkg::PosW'(tun_pkg::FracBits) - pos4_q);
      end
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q[0] <= tun_pkg::EdgeW'(in_req_i.vertex_b_x) - tun_pkg::EdgeW'(in_req_i.vertex_a_x);
      u_q[1] <= tun_pkg::EdgeW'(in_req_i.vertex_b_y) - tun_pkg::EdgeW'(in_req_i.vertex_a_y);
      u_q[2] <= tun_pkg::EdgeW'(in_req_i.vertex_b_z) - tun_pkg::EdgeW'(in_req_i.vertex_a_z);
      v_q[0] <= tun_pkg::EdgeW'(in_req_i.vertex_c_x) - tun_pkg::EdgeW'(in_req_i.vertex_a_x);
      v_q[1] <= tun_pkg::EdgeW'(in_req_i.vertex_c_y) - tun_pkg::EdgeW'(in_req_i.vertex_a_y);
      v_q[2] <= tun_pkg::EdgeW'(in_req_i.vertex_c_z) - tun_pkg::EdgeW'(in_req_i.vertex_a_z);

      pa_q[0] <= u_q[1] * v_q[2];
      pb_q[0] <= u_q[2] * v_q[1];
      pa_q[1] <= u_q[2] * v_q[0];
      pb_q[1] <= u_q[0] * v_q[2];
      pa_q[2] <= u_q[0] * v_q[1];
      pb_q[2] <= u_q[1] * v_q[0];

      for (int i = 0; i < 3; i++) begin
        neg3_q[i] <= n_d[i][tun_pkg::CrossW-1];
        m3_q[i]   <= n_d[i][tun_pkg::CrossW-1] ? tun_pkg::CrossW'(-n_d[i])
                                               : tun_pkg::CrossW'(n_d[i]);
      end

      m4_q   <= m3_q;
      neg4_q <= neg3_q;
      deg4_q <= (or_d == '0);
      pos4_q <= pos_d;

      for (int i = 0; i < 3; i++) begin
        item_q.comp[i] <= sh_d[i][tun_pkg::CompW-1:0];
      end
      item_q.neg   <= neg4_q;
      item_q.degen <= deg4_q;
    end
  end

endmodule

// ===== hw/rtl/tun_fifo.sv =====
// short queue between front and back
`timescale 1ns / 1ps

module tun_fifo #(
  parameter int Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  tun_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output tun_pkg::item_t pop_item_o
);

  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  tun_pkg::item_t mem_q [Depth];
  logic [IdxW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == IdxW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == IdxW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_item_i;
  end

endmodule

// ===== hw/rtl/tun_back.sv =====
// back: squares, pipelined square root, pipelined dividers, output register
`timescale 1ns / 1ps

module tun_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  tun_pkg::item_t     item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tun_pkg::out_req_t  out_req_o
);

  localparam int NStage = 3 + tun_pkg::RootSteps + tun_pkg::DivSteps;

  typedef struct packed {
    logic [35:0]                rem;
    logic [tun_pkg::LenW-1:0]   root;
    logic [tun_pkg::SumW-1:0]   rad;
  } sq_st_t;

  typedef struct packed {
    logic [tun_pkg::LenW:0]     rem;
    logic [tun_pkg::QuotW-1:0]  low;
    logic [tun_pkg::QuotW-1:0]  quo;
  } dv_st_t;

  function automatic sq_st_t sqrt_step(sq_st_t s);
    logic [35:0] r2;
    logic [35:0] trial;
    sq_st_t o;
    r2    = {s.rem[33:0], s.rad[tun_pkg::SumW-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    o.rad = {s.rad[tun_pkg::SumW-3:0], 2'b00};
    if (r2 >= trial) begin
      o.rem  = r2 - trial;
      o.root = {s.root[tun_pkg::LenW-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[tun_pkg::LenW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dv_st_t div_step(dv_st_t s, logic [tun_pkg::LenW-1:0] len);
    logic [tun_pkg::LenW:0] t;
    dv_st_t o;
    t     = {s.rem[tun_pkg::LenW-1:0], s.low[tun_pkg::QuotW-1]};
    o.low = {s.low[tun_pkg::QuotW-2:0], 1'b0};
    if (t >= {1'b0, len}) begin
      o.rem = t - {1'b0, len};
      o.quo = {s.quo[tun_pkg::QuotW-2:0], 1'b1};
    end else begin
      o.rem = t;
      o.quo = {s.quo[tun_pkg::QuotW-2:0], 1'b0};
    end
    return o;
  endfunction

  logic en;
  logic [NStage-1:0] vld_q;
  logic              out_valid_q;

  tun_pkg::item_t             it1_q, it2_q;
  logic [tun_pkg::SqW-1:0]    sq_q [3];
  logic [tun_pkg::SumW-1:0]   sum_q;
  tun_pkg::item_t             s_it_q [tun_pkg::RootSteps];
  sq_st_t                     s_q    [tun_pkg::RootSteps];
  sq_st_t                     s_d    [tun_pkg::RootSteps];
  logic [2:0]                 n_neg_q;
  logic                       n_deg_q;
  logic [tun_pkg::LenW-1:0]   n_len_q;
  logic [tun_pkg::NumW-1:0]   n_num_q [3];
  logic [2:0]                 d_neg_q [tun_pkg::DivSteps];
  logic                       d_deg_q [tun_pkg::DivSteps];
  logic [tun_pkg::LenW-1:0]   d_len_q [tun_pkg::DivSteps];
  dv_st_t                     d_q [tun_pkg::DivSteps][3];
  dv_st_t                     d_d [tun_pkg::DivSteps][3];
  logic [tun_pkg::QuotW-1:0]  cap_d [3];
  logic [tun_pkg::CoordW-1:0] res_d [3];
  tun_pkg::out_req_t          out_q;
  sq_st_t                     s_init;
  dv_st_t                     d_init [3];

  assign en           = !out_valid_q || out_ready_i;
  assign item_ready_o = en;
  assign out_valid_o  = out_valid_q;
  assign out_req_o    = out_q;

  // valid chain and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NStage-2:0], item_valid_i};
      out_valid_q <= vld_q[NStage-1];
    end
  end

  // square root and divider step logic
  always_comb begin
    s_init.rem  = '0;
    s_init.root = '0;
    s_init.rad  = sum_q;
    s_d[0] = sqrt_step(s_init);
    for (int k = 1; k < tun_pkg::RootSteps; k++) begin
      s_d[k] = sqrt_step(s_q[k-1]);
    end
    for (int i = 0; i < 3; i++) begin
      d_init[i].rem = {3'b000, n_num_q[i][tun_pkg::NumW-1 -: 30]};
      d_init[i].low = n_num_q[i][tun_pkg::QuotW-1:0];
      d_init[i].quo = '0;
      d_d[0][i] = div_step(d_init[i], n_len_q);
      for (int k = 1; k < tun_pkg::DivSteps; k++) begin
        d_d[k][i] = div_step(d_q[k-1][i], d_len_q[k-1]);
      end
    end
  end

  // cap, sign and degenerate select
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cap_d[i] = (d_q[tun_pkg::DivSteps-1][i].quo > tun_pkg::OneQ30)
               ? tun_pkg::OneQ30 : d_q[tun_pkg::DivSteps-1][i].quo;
      if (d_deg_q[tun_pkg::DivSteps-1]) begin
        res_d[i] = '0;
      end else if (d_neg_q[tun_pkg::DivSteps-1][i]) begin
        res_d[i] = -cap_d[i];
      end else begin
        res_d[i] = cap_d[i];
      end
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      it1_q <= item_i;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= tun_pkg::SqW'(item_i.comp[i]) * tun_pkg::SqW'(item_i.comp[i]);
      end
      it2_q <= it1_q;
      sum_q <= tun_pkg::SumW'(sq_q[0]) + tun_pkg::SumW'(sq_q[1]) + tun_pkg::SumW'(sq_q[2]);

      s_it_q[0] <= it2_q;
      s_q[0]    <= s_d[0];
      for (int k = 1; k < tun_pkg::RootSteps; k++) begin
        s_it_q[k] <= s_it_q[k-1];
        s_q[k]    <= s_d[k];
      end

      n_neg_q <= s_it_q[tun_pkg::RootSteps-1].neg;
      n_deg_q <= s_it_q[tun_pkg::RootSteps-1].degen;
      n_len_q <= s_q[tun_pkg::RootSteps-1].root;
      for (int i = 0; i < 3; i++) begin
        n_num_q[i] <= {s_it_q[tun_pkg::RootSteps-1].comp[i], {tun_pkg::FracBits{1'b0}}}
                    + tun_pkg::NumW'(s_q[tun_pkg::RootSteps-1].root >> 1);
      end

      d_neg_q[0] <= n_neg_q;
      d_deg_q[0] <= n_deg_q;
      d_len_q[0] <= n_len_q;
      for (int k = 1; k < tun_pkg::DivSteps; k++) begin
        d_neg_q[k] <= d_neg_q[k-1];
        d_deg_q[k] <= d_deg_q[k-1];
        d_len_q[k] <= d_len_q[k-1];
      end
      for (int k = 0; k < tun_pkg::DivSteps; k++) begin
        for (int i = 0; i < 3; i++) begin
          d_q[k][i] <= d_d[k][i];
        end
      end

      out_q.normal_x   <= res_d[0];
      out_q.normal_y   <= res_d[1];
      out_q.normal_z   <= res_d[2];
      out_q.degenerate <= d_deg_q[tun_pkg::DivSteps-1];
    end
  end

endmodule
